// ----- design/multi_channel_tick_timer_pool_defines.svh -----
// assertion macros used by the checker file
`ifndef MULTI_CHANNEL_TICK_TIMER_POOL_DEFINES_SVH
`define MULTI_CHANNEL_TICK_TIMER_POOL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MCTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mctt_pkg.sv -----
// types and constants of the tick timer pool
package mctt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int HANDLE_W       = 4;
  localparam int WORD_W         = 32;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_DUR  = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_NO_SLOT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SS_FREE    = 2'd0,
    SS_READY   = 2'd1,
    SS_RUNNING = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_READ,
    CS_EXEC,
    CS_SCAN,
    CS_TAIL,
    CS_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic [2:0]          operation;
    logic [HANDLE_W-1:0] handle;
    logic                timer_mode;
    logic [WORD_W-1:0]   duration;
    logic [WORD_W-1:0]   tag;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] result_handle;
    logic [WORD_W-1:0]   result_tag;
    logic                last;
  } out_item_t;

  typedef struct packed {
    slot_st_t          st;
    logic              mode;
    logic [WORD_W-1:0] dur;
    logic [WORD_W-1:0] elapsed;
    logic [WORD_W-1:0] tag;
  } slot_t;

  typedef struct packed {
    logic cap;
    logic cmd_rd;
    logic cmd_exec;
    logic scan_rd;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic rd_last;
  } dp_stat_t;

endpackage

// ----- design/mctt_ram.sv -----
// generic single write, single registered read ram
module mctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mctt_ctrl.sv -----
// sequencer for commands and tick sweeps
module mctt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mctt_pkg::dp_stat_t  stat,
  output mctt_pkg::ctl_cmd_t  cmd
);

  mctt_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mctt_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mctt_pkg::CS_IDLE: begin
        if (start) begin
          state_nxt = stat.is_tick ? mctt_pkg::CS_SCAN : mctt_pkg::CS_READ;
        end
      end
      mctt_pkg::CS_READ:  state_nxt = mctt_pkg::CS_EXEC;
      mctt_pkg::CS_EXEC:  state_nxt = mctt_pkg::CS_IDLE;
      mctt_pkg::CS_SCAN: begin
        if (stat.rd_last) begin
          state_nxt = mctt_pkg::CS_TAIL;
        end
      end
      mctt_pkg::CS_TAIL:  state_nxt = mctt_pkg::CS_FLUSH;
      mctt_pkg::CS_FLUSH: state_nxt = mctt_pkg::CS_IDLE;
      default:            state_nxt = mctt_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_r != mctt_pkg::CS_IDLE);
    cmd.cap      = (state_r == mctt_pkg::CS_IDLE) && start;
    cmd.cmd_rd   = (state_r == mctt_pkg::CS_READ);
    cmd.cmd_exec = (state_r == mctt_pkg::CS_EXEC);
    cmd.scan_rd  = (state_r == mctt_pkg::CS_SCAN);
    cmd.flush    = (state_r == mctt_pkg::CS_FLUSH);
  end

endmodule

// ----- design/mctt_dp.sv -----
// slot store, free queue, command execution and tick sweep
module mctt_dp #(
  parameter int NUM_TIMERS = mctt_pkg::NUM_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mctt_pkg::in_item_t  in_data,
  input  mctt_pkg::ctl_cmd_t  cmd,
  output mctt_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output mctt_pkg::out_item_t out_data
);

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int AW = (SW > mctt_pkg::HANDLE_W) ? SW : mctt_pkg::HANDLE_W;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int TW = SW + 2;

  mctt_pkg::in_item_t req_r;
  logic [SW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [NUM_TIMERS-1:0] qvld_r, qvld_nxt;
  logic [NUM_TIMERS-1:0] svld_r, svld_nxt;
  logic [SW-1:0]      idx_r;
  logic               ev_v_r;
  logic [SW-1:0]      ev_idx_r;
  logic               rd_vld_r;
  logic               qrd_vld_r;
  logic               pend_v_r, pend_v_nxt;
  logic [SW-1:0]      pend_h_r, pend_h_nxt;
  logic [mctt_pkg::WORD_W-1:0] pend_tag_r, pend_tag_nxt;
  logic               out_v_r, out_v_nxt;
  mctt_pkg::out_item_t out_r, out_nxt;

  logic [AW-1:0]      h_ext;
  logic               h_ok;
  logic [SW-1:0]      h_slot;
  logic [SW-1:0]      s_raddr;
  mctt_pkg::slot_t    slot_rd;
  logic               s_we;
  logic [SW-1:0]      s_waddr;
  mctt_pkg::slot_t    s_wdata;
  logic [SW-1:0]      q_rd;
  logic               q_we;
  logic [SW-1:0]      tail;
  logic [TW-1:0]      tail_sum;
  logic [SW-1:0]      s_new;
  mctt_pkg::slot_st_t cur_st;
  logic [mctt_pkg::WORD_W-1:0] el_inc;
  logic               fire;

  assign h_ext   = AW'(req_r.handle);
  assign h_ok    = {1'b0, h_ext} < (AW + 1)'(NUM_TIMERS);
  assign h_slot  = h_ext[SW-1:0];
  assign s_raddr = cmd.scan_rd ? idx_r : h_slot;
  assign cur_st  = rd_vld_r ? slot_rd.st : mctt_pkg::SS_FREE;
  assign s_new   = qrd_vld_r ? q_rd : head_r;
  assign el_inc  = slot_rd.elapsed + 1'b1;

  // queue tail wraps once at most
  always_comb begin
    tail_sum = TW'(head_r) + TW'(cnt_r);
    if (tail_sum >= TW'(NUM_TIMERS)) begin
      tail_sum = tail_sum - TW'(NUM_TIMERS);
    end
    tail = tail_sum[SW-1:0];
  end

  assign stat.is_tick = (in_data.operation == mctt_pkg::OP_TICK);
  assign stat.rd_last = (idx_r == SW'(NUM_TIMERS - 1));

  mctt_ram #(.WIDTH($bits(mctt_pkg::slot_t)), .DEPTH(NUM_TIMERS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (slot_rd)
  );

  mctt_ram #(.WIDTH(SW), .DEPTH(NUM_TIMERS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (h_slot),
    .raddr (head_r),
    .rdata (q_rd)
  );

  always_comb begin
    s_we         = 1'b0;
    s_waddr      = h_slot;
    s_wdata      = slot_rd;
    q_we         = 1'b0;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    qvld_nxt     = qvld_r;
    svld_nxt     = svld_r;
    pend_v_nxt   = pend_v_r;
    pend_h_nxt   = pend_h_r;
    pend_tag_nxt = pend_tag_r;
    out_v_nxt    = 1'b0;
    out_nxt      = '0;
    fire         = 1'b0;

    if (cmd.cmd_exec) begin
      out_v_nxt     = 1'b1;
      out_nxt.last  = 1'b1;
      out_nxt.status = mctt_pkg::STS_OK;
      case (req_r.operation)
        mctt_pkg::OP_CREATE: begin
          if (cnt_r == '0) begin
            out_nxt.status = mctt_pkg::STS_NO_SLOT;
          end else begin
            s_we         = 1'b1;
            s_waddr      = s_new;
            s_wdata      = '0;
            s_wdata.st   = mctt_pkg::SS_READY;
            s_wdata.mode = req_r.timer_mode;
            svld_nxt[s_new] = 1'b1;
            head_nxt = (head_r == SW'(NUM_TIMERS - 1)) ? '0 : head_r + 1'b1;
            cnt_nxt  = cnt_r - 1'b1;
            out_nxt.result_handle = mctt_pkg::HANDLE_W'(AW'(s_new));
          end
        end
        mctt_pkg::OP_START: begin
          if (req_r.duration == '0) begin
            out_nxt.status = mctt_pkg::STS_BAD_DUR;
          end else if (!h_ok || cur_st != mctt_pkg::SS_READY) begin
            out_nxt.status = mctt_pkg::STS_NOTFOUND;
          end else begin
            s_we            = 1'b1;
            s_wdata.st      = mctt_pkg::SS_RUNNING;
            s_wdata.dur     = req_r.duration;
            s_wdata.elapsed = '0;
            s_wdata.tag     = req_r.tag;
          end
        end
        mctt_pkg::OP_STOP: begin
          if (!h_ok || cur_st != mctt_pkg::SS_RUNNING) begin
            out_nxt.status = mctt_pkg::STS_NOTFOUND;
          end else begin
            s_we       = 1'b1;
            s_wdata.st = mctt_pkg::SS_READY;
          end
        end
        mctt_pkg::OP_REMOVE: begin
          if (!h_ok || cur_st == mctt_pkg::SS_FREE) begin
            out_nxt.status = mctt_pkg::STS_NOTFOUND;
          end else begin
            s_we       = 1'b1;
            s_wdata.st = mctt_pkg::SS_FREE;
            if (cnt_r < CW'(NUM_TIMERS)) begin
              q_we           = 1'b1;
              qvld_nxt[tail] = 1'b1;
              cnt_nxt        = cnt_r + 1'b1;
            end
          end
        end
        default: out_nxt.status = mctt_pkg::STS_NOTFOUND;
      endcase
    end

    // sweep: one firing slot is held back so the final one can carry last
    if (ev_v_r && cur_st == mctt_pkg::SS_RUNNING) begin
      s_we    = 1'b1;
      s_waddr = ev_idx_r;
      s_wdata.elapsed = el_inc;
      fire = (el_inc >= slot_rd.dur);
      if (fire) begin
        if (slot_rd.mode) begin
          s_wdata.elapsed = '0;
        end else begin
          s_wdata.st = mctt_pkg::SS_READY;
        end
        if (pend_v_r) begin
          out_v_nxt              = 1'b1;
          out_nxt.kind           = 1'b1;
          out_nxt.result_handle  = mctt_pkg::HANDLE_W'(AW'(pend_h_r));
          out_nxt.result_tag     = pend_tag_r;
        end
        pend_v_nxt   = 1'b1;
        pend_h_nxt   = ev_idx_r;
        pend_tag_nxt = slot_rd.tag;
      end
    end

    if (cmd.flush && pend_v_r) begin
      out_v_nxt             = 1'b1;
      out_nxt.kind          = 1'b1;
      out_nxt.result_handle = mctt_pkg::HANDLE_W'(AW'(pend_h_r));
      out_nxt.result_tag    = pend_tag_r;
      out_nxt.last          = 1'b1;
      pend_v_nxt            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      cnt_r    <= CW'(NUM_TIMERS);
      qvld_r   <= '0;
      svld_r   <= '0;
      ev_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      qvld_r   <= qvld_nxt;
      svld_r   <= svld_nxt;
      ev_v_r   <= cmd.scan_rd;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_data;
      idx_r <= '0;
    end else if (cmd.scan_rd) begin
      idx_r <= idx_r + 1'b1;
    end
    ev_idx_r   <= idx_r;
    rd_vld_r   <= svld_r[s_raddr];
    qrd_vld_r  <= qvld_r[head_r];
    pend_h_r   <= pend_h_nxt;
    pend_tag_r <= pend_tag_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- design/multi_channel_tick_timer_pool.sv -----
// top level of the tick timer pool
//
// usage: drive in_data and raise start; the item transfers at a rising edge
// with start high and busy low. create, start, stop and remove each give one
// status result; tick gives one expiry result per firing slot, in slot order,
// and none when no slot fires. the final result of an item has last set.
// results appear on out_data for one cycle with out_valid high; the receiver
// cannot stall, so nothing is held back on the output side.
// a command passes through the read and exec states; its result is registered
// onto out_data as busy drops, and busy is high in those states, so a new
// transfer can follow only once the result of the last one shows.
// a tick sweeps the slot store one slot per cycle through its single read
// port; busy stays high through the sweep and the tail and flush states;
// each expiry waits for the next firing slot so the final one can carry
// last, and that one shows as busy drops.
// reset: all slots free, free queue holds slots in index order, no clearing
// pass is needed, the block leaves reset idle and ready.
module multi_channel_tick_timer_pool #(
  parameter int NUM_TIMERS = mctt_pkg::NUM_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mctt_pkg::in_item_t  in_data,
  output logic                out_valid,
  output mctt_pkg::out_item_t out_data
);

  mctt_pkg::ctl_cmd_t cmd;
  mctt_pkg::dp_stat_t stat;

  mctt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mctt_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- design/mctt_checker.sv -----
// port-level checks of the tick timer pool and their bind
`include "multi_channel_tick_timer_pool_defines.svh"

module mctt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input mctt_pkg::out_item_t out_data
);

  logic st_ok;
  assign st_ok = (out_data.status == mctt_pkg::STS_OK);

  `MCTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transfer left busy low")
  `MCTT_ASSERT_NOW(a_status_single, out_valid && !out_data.kind, out_data.last, "no last")
  `MCTT_ASSERT_NOW(a_status_tag, out_valid && !out_data.kind, out_data.result_tag == '0, "tag")
  `MCTT_ASSERT_NOW(a_expiry_ok, out_valid && out_data.kind, st_ok, "expiry with status")

endmodule

bind multi_channel_tick_timer_pool mctt_checker u_mctt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
